>>> rtl/cdpt_pkg.sv
// package: constants, codes and control structs of the codeword delta pixel toggler
`timescale 1ns / 1ps
`default_nettype none
package cdpt_pkg;

  localparam int unsigned CODEWORD_COUNT = 3706;
  localparam int unsigned SYMBOL_SIDE    = 177;
  localparam int unsigned ROW_BYTES      = 40;
  localparam int unsigned RASTER_BYTES   = 16384;
  localparam int unsigned BORDER_PIXELS  = 4;

  localparam int unsigned MAP_DEPTH   = CODEWORD_COUNT * 8;
  localparam int unsigned MAP_AW      = $clog2(MAP_DEPTH);
  localparam int unsigned CW_AW       = $clog2(CODEWORD_COUNT);
  localparam int unsigned RAS_AW      = $clog2(RASTER_BYTES);
  localparam int unsigned ENTRY_W     = RAS_AW + 3;
  localparam int unsigned SYMBOL_AREA = SYMBOL_SIDE * SYMBOL_SIDE;

  // reciprocal of the symbol side for the position split
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_MUL   = (1 << RECIP_SHIFT) / SYMBOL_SIDE;

  localparam logic [7:0] PIXEL_MSB = 8'h80;

  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_ADVANCE = 3'd1;
  localparam logic [2:0] KIND_PREVIEW = 3'd2;
  localparam logic [2:0] KIND_BASE    = 3'd3;
  localparam logic [2:0] KIND_WRITE   = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  typedef struct packed {
    logic latch;
    logic clear_res;
    logic ld_prep;
    logic ld_mul;
    logic ld_div;
    logic ld_fix;
    logic ld_wr;
    logic prev_rd;
    logic prev_wr;
    logic cw_diff;
    logic map_rd;
    logic ras_rd;
    logic ras_toggle;
    logic ras_host_wr;
    logic ras_host_rd;
    logic rd_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       cw_ok;
    logic       diff_zero;
    logic       pend_zero;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/codeword_delta_pixel_toggler_unit.sv
// top level: codeword delta pixel toggler, controller plus datapath
//
// Input channel (in_valid_i / in_ready_o) takes one item per beat: a map
// load, an advance or preview codeword, a baseline write, or a raster write
// or read. Output channel (out_valid_o / out_ready_i) returns exactly one
// result beat per item, in order.
// Steps from an accepted input beat until the block can accept the next:
//   raster write, baseline, unused kinds, out-of-range codeword: decode only
//   raster read: decode, then capture of the read data
//   map load: decode, a three-step split of the module position into row and
//   column, then the map write
//   advance / preview: decode, codeword diff, then each changed bit costs a map
//   read, a raster read and a raster write through the single-port raster memory
// The result is registered as the controller returns to idle, so its beat is
// offered while the next item can already be taken and put in work.
// When the receiver stalls, a finished item waits in the controller until
// the output register frees up; input is not taken meanwhile.
// Reset clears the controller and the output valid; map, codeword and raster
// stores hold undefined contents until written, and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module codeword_delta_pixel_toggler_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [14:0] entry_index_i,
  input  wire logic [11:0] placement_byte_i,
  input  wire logic [7:0]  placement_mask_i,
  input  wire logic [11:0] codeword_index_i,
  input  wire logic [7:0]  codeword_value_i,
  input  wire logic [13:0] raster_address_i,
  input  wire logic [7:0]  raster_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  read_data_o,
  output logic      [7:0]  toggled_bits_o,
  output logic             error_o
);

  cdpt_pkg::cmd_t cmd;
  cdpt_pkg::sts_t sts;

  cdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdpt_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .placement_byte_i (placement_byte_i),
    .placement_mask_i (placement_mask_i),
    .codeword_index_i (codeword_index_i),
    .codeword_value_i (codeword_value_i),
    .raster_address_i (raster_address_i),
    .raster_data_i    (raster_data_i),
    .read_data_o      (read_data_o),
    .toggled_bits_o   (toggled_bits_o),
    .error_o          (error_o)
  );

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // a load error never comes with codeword or raster data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (toggled_bits_o == 8'd0 && read_data_o == 8'd0))
    else $error("error beat carries data");

  // toggled bits and read data never share a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && toggled_bits_o != 8'd0) |-> (read_data_o == 8'd0))
    else $error("codeword beat carries raster data");

  // a beat is loaded only when the controller finishes, never on the accept edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> !out_valid_o)
    else $error("result beat appeared on the cycle after accept");

endmodule
`default_nettype wire

>>> rtl/cdpt_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cdpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/cdpt_dp.sv
// datapath: item registers, map arithmetic, the three stores and the result register
`timescale 1ns / 1ps
`default_nettype none
module cdpt_dp (
  input  wire logic            clk_i,
  input  wire cdpt_pkg::cmd_t  cmd_i,
  output cdpt_pkg::sts_t       sts_o,
  input  wire logic [2:0]      kind_i,
  input  wire logic [14:0]     entry_index_i,
  input  wire logic [11:0]     placement_byte_i,
  input  wire logic [7:0]      placement_mask_i,
  input  wire logic [11:0]     codeword_index_i,
  input  wire logic [7:0]      codeword_value_i,
  input  wire logic [13:0]     raster_address_i,
  input  wire logic [7:0]      raster_data_i,
  output logic      [7:0]      read_data_o,
  output logic      [7:0]      toggled_bits_o,
  output logic                 error_o
);

  logic [2:0]  kind_q;
  logic [14:0] entry_q;
  logic [11:0] byte_q;
  logic [7:0]  mask_q;
  logic [11:0] cw_q;
  logic [7:0]  value_q;
  logic [13:0] raddr_q;
  logic [7:0]  rdata_q;

  logic [14:0] lin_q;
  logic        bad_q;
  logic [7:0]  qest_q;
  logic [8:0]  rem_q;
  logic [7:0]  y_q;
  logic [7:0]  x_q;
  logic [7:0]  pend_q;

  logic [7:0]  res_read_q;
  logic [7:0]  res_tog_q;
  logic        res_err_q;
  logic [7:0]  out_read_q;
  logic [7:0]  out_tog_q;
  logic        out_err_q;

  logic [2:0]  bit_idx;
  logic        one_hot;
  logic [14:0] lin_d;
  logic        bad_d;
  logic [23:0] prod;
  logic [15:0] qmul;
  logic [15:0] rem_w;
  logic        rem_ge;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [13:0] off;
  logic [2:0]  bsel;
  logic        found;
  logic [7:0]  diff;

  logic                          map_we;
  logic [cdpt_pkg::MAP_AW-1:0]   map_addr;
  logic [cdpt_pkg::ENTRY_W-1:0]  map_wdata;
  logic [cdpt_pkg::ENTRY_W-1:0]  map_rdata;
  logic [7:0]                    prev_rdata;
  logic                          ras_host;
  logic                          ras_we;
  logic                          ras_re;
  logic [cdpt_pkg::RAS_AW-1:0]   ras_addr;
  logic [7:0]                    ras_wdata;
  logic [7:0]                    ras_rdata;

  // placement decode
  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (mask_q[i]) begin
        bit_idx = 3'(i);
      end
    end
    one_hot = (mask_q != 8'd0) && ((mask_q & (mask_q - 8'd1)) == 8'd0);
    lin_d   = {byte_q - 12'd1, bit_idx};
    bad_d   = !one_hot || (byte_q == 12'd0) ||
              (lin_d >= 15'(cdpt_pkg::SYMBOL_AREA));
  end

  // position split and raster offset
  always_comb begin
    prod   = 24'(lin_q) * 24'(cdpt_pkg::RECIP_MUL);
    qmul   = 16'(qest_q) * 16'(cdpt_pkg::SYMBOL_SIDE);
    rem_w  = 16'(lin_q) - qmul;
    rem_ge = rem_q >= 9'(cdpt_pkg::SYMBOL_SIDE);
    row    = y_q + 8'(cdpt_pkg::BORDER_PIXELS);
    col    = x_q + 8'(cdpt_pkg::BORDER_PIXELS);
    off    = 14'(row) * 14'(cdpt_pkg::ROW_BYTES) + 14'(col[7:3]);
  end

  // next changed bit, msb of the codeword first
  always_comb begin
    bsel  = '0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_q[i] && !found) begin
        bsel  = 3'(7 - i);
        found = 1'b1;
      end
    end
  end

  assign diff = value_q ^ prev_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      entry_q <= entry_index_i;
      byte_q  <= placement_byte_i;
      mask_q  <= placement_mask_i;
      cw_q    <= codeword_index_i;
      value_q <= codeword_value_i;
      raddr_q <= raster_address_i;
      rdata_q <= raster_data_i;
    end
    if (cmd_i.clear_res) begin
      res_read_q <= '0;
      res_tog_q  <= '0;
      res_err_q  <= 1'b0;
    end
    if (cmd_i.ld_prep) begin
      lin_q <= lin_d;
      bad_q <= bad_d;
    end
    if (cmd_i.ld_mul) begin
      qest_q <= prod[cdpt_pkg::RECIP_SHIFT +: 8];
    end
    if (cmd_i.ld_div) begin
      rem_q <= rem_w[8:0];
    end
    if (cmd_i.ld_fix) begin
      y_q <= rem_ge ? qest_q + 8'd1 : qest_q;
      x_q <= rem_ge ? 8'(rem_q - 9'(cdpt_pkg::SYMBOL_SIDE)) : rem_q[7:0];
    end
    if (cmd_i.ld_wr) begin
      res_err_q <= bad_q;
    end
    if (cmd_i.cw_diff) begin
      res_tog_q <= diff;
      pend_q    <= diff;
    end
    if (cmd_i.map_rd) begin
      pend_q <= pend_q & ~(cdpt_pkg::PIXEL_MSB >> bsel);
    end
    if (cmd_i.rd_capture) begin
      res_read_q <= ras_rdata;
    end
    if (cmd_i.out_load) begin
      out_read_q <= res_read_q;
      out_tog_q  <= res_tog_q;
      out_err_q  <= res_err_q;
    end
  end

  assign map_we    = cmd_i.ld_wr && !bad_q && (entry_q < 15'(cdpt_pkg::MAP_DEPTH));
  assign map_addr  = cmd_i.ld_wr ? entry_q : {cw_q, bsel};
  assign map_wdata = {off, col[2:0]};

  cdpt_ram #(
    .WIDTH (cdpt_pkg::ENTRY_W),
    .DEPTH (cdpt_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .re_i    (cmd_i.map_rd),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  cdpt_ram #(
    .WIDTH (8),
    .DEPTH (cdpt_pkg::CODEWORD_COUNT)
  ) u_prev (
    .clk_i   (clk_i),
    .we_i    (cmd_i.prev_wr),
    .re_i    (cmd_i.prev_rd),
    .addr_i  (cw_q),
    .wdata_i (value_q),
    .rdata_o (prev_rdata)
  );

  assign ras_host  = cmd_i.ras_host_wr || cmd_i.ras_host_rd;
  assign ras_we    = cmd_i.ras_host_wr || cmd_i.ras_toggle;
  assign ras_re    = cmd_i.ras_host_rd || cmd_i.ras_rd;
  assign ras_addr  = ras_host ? raddr_q : map_rdata[cdpt_pkg::ENTRY_W-1:3];
  assign ras_wdata = cmd_i.ras_host_wr ? rdata_q
                                       : ras_rdata ^ (cdpt_pkg::PIXEL_MSB >> map_rdata[2:0]);

  cdpt_ram #(
    .WIDTH (8),
    .DEPTH (cdpt_pkg::RASTER_BYTES)
  ) u_raster (
    .clk_i   (clk_i),
    .we_i    (ras_we),
    .re_i    (ras_re),
    .addr_i  (ras_addr),
    .wdata_i (ras_wdata),
    .rdata_o (ras_rdata)
  );

  assign sts_o.kind      = kind_q;
  assign sts_o.cw_ok     = cw_q < 12'(cdpt_pkg::CODEWORD_COUNT);
  assign sts_o.diff_zero = diff == 8'd0;
  assign sts_o.pend_zero = pend_q == 8'd0;

  assign read_data_o    = out_read_q;
  assign toggled_bits_o = out_tog_q;
  assign error_o        = out_err_q;

endmodule
`default_nettype wire

>>> rtl/cdpt_ctrl.sv
// controller: sequencing state machine and output beat valid
`timescale 1ns / 1ps
`default_nettype none
module cdpt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire cdpt_pkg::sts_t sts_i,
  output cdpt_pkg::cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_DECODE  = 12'b0000_0000_0010,
    S_LD_MUL  = 12'b0000_0000_0100,
    S_LD_DIV  = 12'b0000_0000_1000,
    S_LD_FIX  = 12'b0000_0001_0000,
    S_LD_WR   = 12'b0000_0010_0000,
    S_CW_DIFF = 12'b0000_0100_0000,
    S_MAP_RD  = 12'b0000_1000_0000,
    S_RAS_RD  = 12'b0001_0000_0000,
    S_RAS_WR  = 12'b0010_0000_0000,
    S_RD_CAP  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.clear_res = 1'b1;
        state_d         = S_DONE;
        case (sts_i.kind)
          cdpt_pkg::KIND_LOAD: begin
            cmd_o.ld_prep = 1'b1;
            state_d       = S_LD_MUL;
          end
          cdpt_pkg::KIND_ADVANCE, cdpt_pkg::KIND_PREVIEW: begin
            if (sts_i.cw_ok) begin
              cmd_o.prev_rd = 1'b1;
              state_d       = S_CW_DIFF;
            end
          end
          cdpt_pkg::KIND_BASE: begin
            cmd_o.prev_wr = sts_i.cw_ok;
          end
          cdpt_pkg::KIND_WRITE: begin
            cmd_o.ras_host_wr = 1'b1;
          end
          cdpt_pkg::KIND_READ: begin
            cmd_o.ras_host_rd = 1'b1;
            state_d           = S_RD_CAP;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_LD_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = S_LD_DIV;
      end
      S_LD_DIV: begin
        cmd_o.ld_div = 1'b1;
        state_d      = S_LD_FIX;
      end
      S_LD_FIX: begin
        cmd_o.ld_fix = 1'b1;
        state_d      = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.ld_wr = 1'b1;
        state_d     = S_DONE;
      end
      S_CW_DIFF: begin
        cmd_o.cw_diff = 1'b1;
        cmd_o.prev_wr = sts_i.kind == cdpt_pkg::KIND_ADVANCE;
        state_d       = sts_i.diff_zero ? S_DONE : S_MAP_RD;
      end
      S_MAP_RD: begin
        cmd_o.map_rd = 1'b1;
        state_d      = S_RAS_RD;
      end
      S_RAS_RD: begin
        cmd_o.ras_rd = 1'b1;
        state_d      = S_RAS_WR;
      end
      S_RAS_WR: begin
        cmd_o.ras_toggle = 1'b1;
        state_d          = sts_i.pend_zero ? S_DONE : S_MAP_RD;
      end
      S_RD_CAP: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> dv/codeword_delta_pixel_toggler_unit_tb.sv
// testbench: codeword delta pixel toggler, directed table then random beats
`timescale 1ns / 1ps
module codeword_delta_pixel_toggler_unit_tb;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned RESET_CYCLES  = 2;
  localparam int unsigned RANDOM_BEATS  = 1100;
  localparam int unsigned PHASE_COUNT   = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned IDLE_HEAVY    = 83;
  localparam int unsigned IDLE_LIGHT    = 19;
  localparam int unsigned MAX_BYTE_NO   = 4095;
  localparam int unsigned MAX_ENTRY_NO  = 32767;
  localparam int unsigned MAX_CW_NO     = 4095;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam bit TYPED   = 1'b1;
  localparam bit MODELED = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] entry_index;
    logic [11:0] placement_byte;
    logic [7:0]  placement_mask;
    logic [11:0] cw_index;
    logic [7:0]  cw_value;
    logic [13:0] raster_address;
    logic [7:0]  raster_data;
  } beat_t;

  localparam int unsigned BEAT_W = $bits(beat_t);

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] toggled_bits;
    logic       error;
  } resp_t;

  typedef struct packed {
    beat_t bt;
    bit    typed;
    resp_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic [14:0] entry_index_i = '0;
  logic [11:0] placement_byte_i = '0;
  logic [7:0]  placement_mask_i = '0;
  logic [11:0] codeword_index_i = '0;
  logic [7:0]  codeword_value_i = '0;
  logic [13:0] raster_address_i = '0;
  logic [7:0]  raster_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [7:0]  toggled_bits_o;
  logic        error_o;

  // mirror of the block state
  int unsigned map_offset [cdpt_pkg::MAP_DEPTH];
  logic [2:0]  map_pixel [cdpt_pkg::MAP_DEPTH];
  bit          map_loaded [cdpt_pkg::MAP_DEPTH];
  logic [7:0]  last_codeword [cdpt_pkg::CODEWORD_COUNT];
  bit          codeword_known [cdpt_pkg::CODEWORD_COUNT];
  logic [7:0]  raster_image [cdpt_pkg::RASTER_BYTES];
  bit          raster_known [cdpt_pkg::RASTER_BYTES];
  int unsigned live_codewords [$];
  int unsigned written_rasters [$];

  resp_t       pending_pixel_results [$];
  resp_t       head_result;
  int unsigned mismatches = 0;
  int unsigned counted_beats = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  codeword_delta_pixel_toggler_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .placement_byte_i (placement_byte_i),
    .placement_mask_i (placement_mask_i),
    .codeword_index_i (codeword_index_i),
    .codeword_value_i (codeword_value_i),
    .raster_address_i (raster_address_i),
    .raster_data_i    (raster_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .toggled_bits_o   (toggled_bits_o),
    .error_o          (error_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic place_module(input logic [14:0] idx, input logic [11:0] byte_no,
                                        input logic [7:0] mask);
    int unsigned b, bitpos, linear, row, col;
    bitpos = 8;
    for (b = 0; b < 8; b++) begin
      if (mask == (8'd1 << b)) bitpos = b;
    end
    if (bitpos == 8 || byte_no == 0) return 1'b1;
    linear = (byte_no - 1) * 8 + bitpos;
    if (linear >= cdpt_pkg::SYMBOL_AREA) return 1'b1;
    if (idx >= cdpt_pkg::MAP_DEPTH) return 1'b0;
    row = linear / cdpt_pkg::SYMBOL_SIDE;
    col = linear % cdpt_pkg::SYMBOL_SIDE + cdpt_pkg::BORDER_PIXELS;
    map_offset[idx] = (row + cdpt_pkg::BORDER_PIXELS) * cdpt_pkg::ROW_BYTES + (col >> 3);
    map_pixel[idx]  = col[2:0];
    map_loaded[idx] = 1'b1;
    return 1'b0;
  endfunction

  function automatic void note_codeword(input int unsigned cw, input logic [7:0] value);
    if (!codeword_known[cw]) live_codewords.push_back(cw);
    codeword_known[cw] = 1'b1;
    last_codeword[cw]  = value;
  endfunction

  function automatic resp_t raster_delta_response(input beat_t bt);
    resp_t       r;
    logic [7:0]  diff;
    int unsigned b, e, addr;
    r = '0;
    addr = bt.raster_address % cdpt_pkg::RASTER_BYTES;
    case (bt.kind)
      cdpt_pkg::KIND_LOAD: begin
        r.error = place_module(bt.entry_index, bt.placement_byte, bt.placement_mask);
      end
      cdpt_pkg::KIND_ADVANCE, cdpt_pkg::KIND_PREVIEW: begin
        if (bt.cw_index < cdpt_pkg::CODEWORD_COUNT) begin
          diff = bt.cw_value ^ last_codeword[bt.cw_index];
          for (b = 0; b < 8; b++) begin
            if (diff[7 - b]) begin
              e = bt.cw_index * 8 + b;
              raster_image[map_offset[e] % cdpt_pkg::RASTER_BYTES] ^=
                cdpt_pkg::PIXEL_MSB >> map_pixel[e];
            end
          end
          if (bt.kind == cdpt_pkg::KIND_ADVANCE) note_codeword(32'(bt.cw_index), bt.cw_value);
          r.toggled_bits = diff;
        end
      end
      cdpt_pkg::KIND_BASE: begin
        if (bt.cw_index < cdpt_pkg::CODEWORD_COUNT) note_codeword(32'(bt.cw_index), bt.cw_value);
      end
      cdpt_pkg::KIND_WRITE: begin
        if (!raster_known[addr]) written_rasters.push_back(addr);
        raster_known[addr] = 1'b1;
        raster_image[addr] = bt.raster_data;
      end
      cdpt_pkg::KIND_READ: r.read_data = raster_image[addr];
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit beat_is_ignored(input beat_t bt, input resp_t r);
    case (bt.kind)
      cdpt_pkg::KIND_LOAD: return bt.entry_index >= cdpt_pkg::MAP_DEPTH && !r.error;
      cdpt_pkg::KIND_ADVANCE, cdpt_pkg::KIND_PREVIEW, cdpt_pkg::KIND_BASE:
        return bt.cw_index >= cdpt_pkg::CODEWORD_COUNT;
      cdpt_pkg::KIND_WRITE, cdpt_pkg::KIND_READ: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  // codeword bits whose pixel can be toggled without touching unwritten stores
  function automatic logic [7:0] reachable_bits(input int unsigned cw);
    logic [7:0]  m;
    int unsigned b, e;
    m = '0;
    for (b = 0; b < 8; b++) begin
      e = cw * 8 + b;
      if (map_loaded[e] && raster_known[map_offset[e] % cdpt_pkg::RASTER_BYTES]) m[7 - b] = 1'b1;
    end
    return m;
  endfunction

  function automatic beat_t random_beat(input logic [2:0] k);
    beat_t bt;
    bt = BEAT_W'({$urandom, $urandom, $urandom});
    bt.kind = k;
    return bt;
  endfunction

  function automatic beat_t codeword_beat(input logic [2:0] k, input int unsigned cw);
    beat_t      bt;
    logic [7:0] flips;
    bt = random_beat(k);
    flips = 8'($urandom);
    bt.cw_index = 12'(cw);
    bt.cw_value = last_codeword[cw] ^ (flips & reachable_bits(cw));
    return bt;
  endfunction

  function automatic beat_t with_placement(input beat_t bt, input bit good);
    int unsigned linear;
    logic [7:0]  m;
    if (good) begin
      linear = $urandom_range(0, cdpt_pkg::SYMBOL_AREA - 1);
      bt.placement_byte = 12'(linear / 8 + 1);
      bt.placement_mask = 8'd1 << (linear % 8);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          bt.placement_byte = '0;
          bt.placement_mask = 8'd1 << $urandom_range(0, 7);
        end
        1: begin
          m = 8'($urandom);
          while ($countones(m) == 1) m = 8'($urandom);
          bt.placement_mask = m;
        end
        default: begin
          linear = $urandom_range(cdpt_pkg::SYMBOL_AREA, (MAX_BYTE_NO - 1) * 8 + 7);
          bt.placement_byte = 12'(linear / 8 + 1);
          bt.placement_mask = 8'd1 << (linear % 8);
        end
      endcase
    end
    return bt;
  endfunction

  function automatic dir_row_t drow(input logic [2:0] k, input int unsigned a, b, c,
                                    input bit typed, input logic [7:0] rd, tg,
                                    input logic er);
    dir_row_t r;
    r = '0;
    r.bt.kind = k;
    case (k)
      cdpt_pkg::KIND_LOAD: begin
        r.bt.entry_index    = 15'(a);
        r.bt.placement_byte = 12'(b);
        r.bt.placement_mask = 8'(c);
      end
      cdpt_pkg::KIND_ADVANCE, cdpt_pkg::KIND_PREVIEW, cdpt_pkg::KIND_BASE: begin
        r.bt.cw_index = 12'(a);
        r.bt.cw_value = 8'(b);
      end
      cdpt_pkg::KIND_WRITE, cdpt_pkg::KIND_READ: begin
        r.bt.raster_address = 14'(a);
        r.bt.raster_data    = 8'(b);
      end
      default: ;
    endcase
    r.typed             = typed;
    r.want.read_data    = rd;
    r.want.toggled_bits = tg;
    r.want.error        = er;
    return r;
  endfunction

  task automatic send_beat(input beat_t bt, input bit typed, input resp_t typed_resp);
    resp_t modeled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    kind_i           <= bt.kind;
    entry_index_i    <= bt.entry_index;
    placement_byte_i <= bt.placement_byte;
    placement_mask_i <= bt.placement_mask;
    codeword_index_i <= bt.cw_index;
    codeword_value_i <= bt.cw_value;
    raster_address_i <= bt.raster_address;
    raster_data_i    <= bt.raster_data;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    modeled = raster_delta_response(bt);
    pending_pixel_results.push_back(typed ? typed_resp : modeled);
    if (!beat_is_ignored(bt, modeled)) counted_beats++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixel_results.size() != 0);
  endtask

  // baseline, full map, raster bytes under the map, a codeword run, a read back
  task automatic codeword_story(input int unsigned cw);
    beat_t       bt;
    int unsigned b, addr;
    bt = random_beat(cdpt_pkg::KIND_BASE);
    bt.cw_index = 12'(cw);
    send_beat(bt, MODELED, '0);
    for (b = 0; b < 8; b++) begin
      bt = random_beat(cdpt_pkg::KIND_LOAD);
      bt.entry_index = 15'(cw * 8 + b);
      bt = with_placement(bt, 1'b1);
      send_beat(bt, MODELED, '0);
    end
    for (b = 0; b < 8; b++) begin
      addr = map_offset[cw * 8 + b] % cdpt_pkg::RASTER_BYTES;
      if (!raster_known[addr]) begin
        bt = random_beat(cdpt_pkg::KIND_WRITE);
        bt.raster_address = 14'(addr);
        send_beat(bt, MODELED, '0);
      end
    end
    repeat ($urandom_range(2, 6)) begin
      bt = codeword_beat($urandom_range(0, 1) ? cdpt_pkg::KIND_ADVANCE : cdpt_pkg::KIND_PREVIEW,
                         cw);
      send_beat(bt, MODELED, '0);
    end
    // a preview sent twice leaves the raster as it was
    bt = codeword_beat(cdpt_pkg::KIND_PREVIEW, cw);
    send_beat(bt, MODELED, '0);
    send_beat(bt, MODELED, '0);
    bt = random_beat(cdpt_pkg::KIND_READ);
    bt.raster_address = 14'(map_offset[cw * 8 + $urandom_range(0, 7)] % cdpt_pkg::RASTER_BYTES);
    send_beat(bt, MODELED, '0);
  endtask

  task automatic random_item();
    beat_t       bt;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35 && live_codewords.size() != 0) begin
      bt = codeword_beat($urandom_range(0, 1) ? cdpt_pkg::KIND_ADVANCE : cdpt_pkg::KIND_PREVIEW,
                         live_codewords[$urandom_range(0, live_codewords.size() - 1)]);
    end else if (pick < 50) begin
      bt = random_beat(cdpt_pkg::KIND_LOAD);
      case ($urandom_range(0, 9))
        0: begin
          bt.entry_index = 15'($urandom_range(cdpt_pkg::MAP_DEPTH, MAX_ENTRY_NO));
          bt = with_placement(bt, 1'b1);
        end
        1, 2: bt = with_placement(bt, 1'b0);
        default: begin
          bt.entry_index = 15'($urandom_range(0, cdpt_pkg::MAP_DEPTH - 1));
          bt = with_placement(bt, 1'b1);
        end
      endcase
    end else if (pick < 62) begin
      bt = random_beat(cdpt_pkg::KIND_WRITE);
    end else if (pick < 75 && written_rasters.size() != 0) begin
      bt = random_beat(cdpt_pkg::KIND_READ);
      bt.raster_address =
        14'(written_rasters[$urandom_range(0, written_rasters.size() - 1)]);
    end else if (pick < 88) begin
      bt = random_beat(cdpt_pkg::KIND_BASE);
      bt.cw_index = 12'($urandom_range(0, cdpt_pkg::CODEWORD_COUNT - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: bt = random_beat(KIND_SPARE_LO);
        1: bt = random_beat(KIND_SPARE_HI);
        2: bt = random_beat(cdpt_pkg::KIND_BASE);
        default: bt = random_beat($urandom_range(0, 1) ? cdpt_pkg::KIND_ADVANCE
                                                        : cdpt_pkg::KIND_PREVIEW);
      endcase
      if (bt.kind != KIND_SPARE_LO && bt.kind != KIND_SPARE_HI)
        bt.cw_index = 12'($urandom_range(cdpt_pkg::CODEWORD_COUNT, MAX_CW_NO));
    end
    send_beat(bt, MODELED, '0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixel_results.size() == 0) begin
        $error("result beat with no result pending");
        mismatches++;
      end else begin
        head_result = pending_pixel_results.pop_front();
        check_field("read_data", head_result.read_data, read_data_o);
        check_field("toggled_bits", head_result.toggled_bits, toggled_bits_o);
        check_field("error", {7'd0, head_result.error}, {7'd0, error_o});
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t    rows [$];
    int unsigned phase, target, cw;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(drow(cdpt_pkg::KIND_WRITE,   0,     8'hFF, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_READ,    0,     0,     0,     TYPED,   8'hFF, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_WRITE,   16383, 8'h00, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_READ,    16383, 0,     0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    0,     1,     8'h01, TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    29647, 3917,  8'h01, TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    5,     10,    8'h03, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    6,     0,     8'h80, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    7,     3917,  8'h02, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    8,     4095,  8'h80, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    9,     20,    8'h00, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    29648, 1,     8'h01, TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_LOAD,    32767, 1,     8'hFF, TYPED,   8'h00, 8'h00, 1'b1));
    rows.push_back(drow(cdpt_pkg::KIND_WRITE,   160,   8'h0F, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_WRITE,   7222,  8'hA5, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_BASE,    0,     8'h00, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_BASE,    3705,  8'hFF, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_ADVANCE, 0,     8'h80, 0,     MODELED, 8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_READ,    160,   0,     0,     MODELED, 8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_PREVIEW, 3705,  8'hFE, 0,     MODELED, 8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_PREVIEW, 3705,  8'hFE, 0,     MODELED, 8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_READ,    7222,  0,     0,     MODELED, 8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_ADVANCE, 4095,  8'hFF, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(cdpt_pkg::KIND_BASE,    3706,  8'h55, 0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(KIND_SPARE_LO,          0,     0,     0,     TYPED,   8'h00, 8'h00, 1'b0));
    rows.push_back(drow(KIND_SPARE_HI,          0,     0,     0,     TYPED,   8'h00, 8'h00, 1'b0));
    foreach (rows[i]) send_beat(rows[i].bt, rows[i].typed, rows[i].want);
    wait_results_drained();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          rx_stall_pct <= 0;
          hold_req     <= hold_req + 1;
        end
        1: begin
          send_idle_pct = IDLE_HEAVY;
          rx_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          rx_stall_pct <= IDLE_HEAVY;
        end
        default: begin
          send_idle_pct = IDLE_LIGHT;
          rx_stall_pct <= IDLE_LIGHT;
        end
      endcase
      target = counted_beats + RANDOM_BEATS / PHASE_COUNT;
      while (counted_beats < target) begin
        if ($urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 7))
            0: cw = 0;
            1: cw = cdpt_pkg::CODEWORD_COUNT - 1;
            default: cw = $urandom_range(0, cdpt_pkg::CODEWORD_COUNT - 1);
          endcase
          codeword_story(cw);
        end else begin
          random_item();
        end
      end
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
